// ===== design/ptw_pkg.sv =====
// ptw_pkg: command and status codes, entry flag bits and field widths
// shared by the page table walker interfaces and the top level.
// No dependencies.
`timescale 1ns / 1ps
package ptw_pkg;

  // command codes
  localparam logic [1:0] CMD_MAP     = 2'd0;
  localparam logic [1:0] CMD_RESOLVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // field widths
  localparam int unsigned VA_W    = 64;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned FRAME_W = 40;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;

  // page table entry flags
  localparam logic [ENTRY_W-1:0] F_PRESENT  = 64'h1;
  localparam logic [ENTRY_W-1:0] F_WRITE    = 64'h2;
  localparam logic [ENTRY_W-1:0] F_USER     = 64'h4;
  localparam logic [ENTRY_W-1:0] F_ACCESSED = 64'h20;
  localparam logic [ENTRY_W-1:0] F_GLOBAL   = 64'h100;
  localparam int unsigned        LARGE_BIT  = 7;

  localparam logic [ENTRY_W-1:0] LARGE_MASK = 64'h1FFFFF;
  localparam logic [ENTRY_W-1:0] PAGE_MASK  = 64'hFFF;

endpackage

// ===== design/ptw_if.sv =====
// ptw_if: valid/ready channels of the page table walker (request,
// response and configuration write). Depends on ptw_pkg.
`timescale 1ns / 1ps
interface ptw_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [ptw_pkg::VA_W-1:0]    virtual_address;
  logic [ptw_pkg::PA_W-1:0]    physical_address;
  logic [ptw_pkg::CNT_W-1:0]   page_count;
  logic                        global_mapping;

  modport source (output valid, cmd, virtual_address, physical_address, page_count,
                  global_mapping, input ready);
  modport sink   (input valid, cmd, virtual_address, physical_address, page_count,
                  global_mapping, output ready);
endinterface

interface ptw_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ptw_pkg::VA_W-1:0]    resolved_address;
  logic [ptw_pkg::CNT_W-1:0]   pages_mapped;

  modport source (output valid, status, resolved_address, pages_mapped, input ready);
  modport sink   (input valid, status, resolved_address, pages_mapped, output ready);
endinterface

interface ptw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptw_pkg::FRAME_W-1:0]   table_base_frame;

  modport source (output valid, table_base_frame, input ready);
  modport sink   (input valid, table_base_frame, output ready);
endinterface

// ===== design/four_level_page_table_walker_unit.sv =====
// Four-level page table walker: table store, bump allocator and a
// sequencer sharing one memory port. Depends on ptw_pkg and ptw_if.
// Resolve reads one table entry per level through the one memory port;
// map links a new table where an entry is empty, zeroing a stale slot first;
// clear-kernel zeroes root entries 256..511. One command at a time.
// Reset: control cleared at once, then a pass over all TABLE_PAGES*512
// entries zeroes the store; no request is taken until it ends.
`timescale 1ns / 1ps
module four_level_page_table_walker_unit #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptw_cfg_if.sink   cfg_i,
  ptw_req_if.sink   req_i,
  ptw_rsp_if.source rsp_o
);

  localparam int unsigned SLOT_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int unsigned NF_W      = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AW        = SLOT_W + ptw_pkg::IDX_W;
  localparam int unsigned MEM_DEPTH = TABLE_PAGES * 512;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RD   = 9'b000000100,
    S_EVAL = 9'b000001000,
    S_ZERO = 9'b000010000,
    S_LINK = 9'b000100000,
    S_LEAF = 9'b001000000,
    S_KCLR = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_e;

  state_e                       state_q, state_d;
  logic [AW-1:0]                cnt_q, cnt_d;
  logic [1:0]                   level_q, level_d;     // table level minus one
  logic [SLOT_W-1:0]            slot_q, slot_d;
  logic [SLOT_W-1:0]            new_slot_q, new_slot_d;
  logic [NF_W-1:0]              nf_q, nf_d;
  logic [ptw_pkg::FRAME_W-1:0]  base_q;
  logic [TABLE_PAGES-1:0]       dirty_q;
  logic                         out_valid_q, out_valid_d;

  logic [1:0]                   cmd_q, cmd_d;
  logic [ptw_pkg::VA_W-1:0]     va_q, va_d;
  logic [ptw_pkg::PA_W-1:0]     pa_q, pa_d;
  logic [ptw_pkg::CNT_W-1:0]    count_q, count_d;
  logic [ptw_pkg::CNT_W-1:0]    done_q, done_d;
  logic                         glob_q, glob_d;
  logic [1:0]                   status_q, status_d;
  logic [ptw_pkg::VA_W-1:0]     res_q, res_d;
  logic [1:0]                   out_status_q, out_status_d;
  logic [ptw_pkg::VA_W-1:0]     out_res_q, out_res_d;
  logic [ptw_pkg::CNT_W-1:0]    out_done_q, out_done_d;

  logic [ptw_pkg::ENTRY_W-1:0]  mem_q [MEM_DEPTH];
  logic [ptw_pkg::ENTRY_W-1:0]  rdata_q;
  logic                         we, re;
  logic [AW-1:0]                waddr;
  logic [ptw_pkg::ENTRY_W-1:0]  wdata;
  logic                         dirty_set, dirty_clr;

  logic [ptw_pkg::IDX_W-1:0]    idx;
  logic [ptw_pkg::FRAME_W-1:0]  diff;
  logic                         in_store;
  logic [ptw_pkg::ENTRY_W-1:0]  user_flag, dir_flags, leaf_flags;
  logic [ptw_pkg::FRAME_W-1:0]  new_frame;
  logic [ptw_pkg::CNT_W-1:0]    done_inc;

  // handshakes
  assign cfg_i.ready            = 1'b1;
  assign req_i.ready            = (state_q == S_IDLE);
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.resolved_address = out_res_q;
  assign rsp_o.pages_mapped     = out_done_q;

  // table index of the current level
  always_comb begin
    case (level_q)
      2'd0:    idx = va_q[12 +: 9];
      2'd1:    idx = va_q[21 +: 9];
      2'd2:    idx = va_q[30 +: 9];
      2'd3:    idx = va_q[39 +: 9];
      default: idx = va_q[12 +: 9];
    endcase
  end

  // slot named by the entry just read
  assign diff      = rdata_q[51:12] - base_q;
  assign in_store  = (diff < ptw_pkg::FRAME_W'(TABLE_PAGES));
  assign user_flag = glob_q ? '0 : ptw_pkg::F_USER;
  assign dir_flags = ptw_pkg::F_PRESENT | ptw_pkg::F_WRITE | user_flag
                   | ((level_q == 2'd1) ? '0 : ptw_pkg::F_ACCESSED);
  assign leaf_flags = ptw_pkg::F_PRESENT | ptw_pkg::F_WRITE
                    | (glob_q ? ptw_pkg::F_GLOBAL : ptw_pkg::F_USER);
  assign new_frame = base_q + ptw_pkg::FRAME_W'(new_slot_q);
  assign done_inc  = done_q + ptw_pkg::CNT_W'(1);

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    level_d      = level_q;
    slot_d       = slot_q;
    new_slot_d   = new_slot_q;
    nf_d         = nf_q;
    cmd_d        = cmd_q;
    va_d         = va_q;
    pa_d         = pa_q;
    count_d      = count_q;
    done_d       = done_q;
    glob_d       = glob_q;
    status_d     = status_q;
    res_d        = res_q;
    out_status_d = out_status_q;
    out_res_d    = out_res_q;
    out_done_d   = out_done_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = {slot_q, idx};
    wdata        = '0;
    dirty_set    = 1'b0;
    dirty_clr    = 1'b0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == AW'(MEM_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = req_i.cmd;
          va_d     = req_i.virtual_address;
          pa_d     = req_i.physical_address;
          count_d  = req_i.page_count;
          glob_d   = req_i.global_mapping;
          done_d   = '0;
          status_d = ptw_pkg::ST_OK;
          res_d    = '0;
          level_d  = 2'd3;
          slot_d   = '0;
          cnt_d    = '0;
          case (req_i.cmd)
            ptw_pkg::CMD_MAP:     state_d = (req_i.page_count == '0) ? S_FIN : S_RD;
            ptw_pkg::CMD_RESOLVE: state_d = S_RD;
            ptw_pkg::CMD_CLEAR:   state_d = S_KCLR;
            default:              state_d = S_FIN;
          endcase
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (cmd_q == ptw_pkg::CMD_MAP) begin
          if (rdata_q == '0) begin
            if (nf_q >= NF_W'(TABLE_PAGES)) begin
              status_d = ptw_pkg::ST_FULL;
              state_d  = S_FIN;
            end else begin
              new_slot_d = nf_q[SLOT_W-1:0];
              nf_d       = nf_q + NF_W'(1);
              cnt_d      = '0;
              state_d    = dirty_q[nf_q[SLOT_W-1:0]] ? S_ZERO : S_LINK;
            end
          end else if (!in_store) begin
            status_d = ptw_pkg::ST_OUTSIDE;
            state_d  = S_FIN;
          end else begin
            slot_d  = diff[SLOT_W-1:0];
            level_d = level_q - 2'd1;
            state_d = (level_q == 2'd1) ? S_LEAF : S_RD;
          end
        end else begin
          if (level_q == 2'd0) begin
            res_d   = (rdata_q & ~ptw_pkg::PAGE_MASK) | {52'd0, va_q[11:0]};
            state_d = S_FIN;
          end else if (level_q == 2'd1 && rdata_q[ptw_pkg::LARGE_BIT]) begin
            res_d   = (rdata_q & ~ptw_pkg::LARGE_MASK) | {43'd0, va_q[20:0]};
            state_d = S_FIN;
          end else if (!in_store) begin
            status_d = ptw_pkg::ST_OUTSIDE;
            state_d  = S_FIN;
          end else begin
            slot_d  = diff[SLOT_W-1:0];
            level_d = level_q - 2'd1;
            state_d = S_RD;
          end
        end
      end
      // zero a stale slot before it is linked in
      S_ZERO: begin
        we    = 1'b1;
        waddr = {new_slot_q, cnt_q[8:0]};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[8:0] == 9'h1FF) begin
          dirty_clr = 1'b1;
          state_d   = S_LINK;
        end
      end
      S_LINK: begin
        we        = 1'b1;
        wdata     = {12'd0, new_frame, 12'd0} | dir_flags;
        dirty_set = 1'b1;
        slot_d    = new_slot_q;
        level_d   = level_q - 2'd1;
        state_d   = (level_q == 2'd1) ? S_LEAF : S_RD;
      end
      S_LEAF: begin
        we        = 1'b1;
        wdata     = {12'd0, pa_q} | leaf_flags;
        dirty_set = 1'b1;
        done_d    = done_inc;
        if (done_inc == count_q) begin
          state_d = S_FIN;
        end else begin
          va_d    = va_q + ptw_pkg::VA_W'(4096);
          pa_d    = pa_q + ptw_pkg::PA_W'(4096);
          level_d = 2'd3;
          slot_d  = '0;
          state_d = S_RD;
        end
      end
      // root entries 256..511
      S_KCLR: begin
        we    = 1'b1;
        waddr = {SLOT_W'(0), 1'b1, cnt_q[7:0]};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[7:0] == 8'hFF) state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_status_d = status_q;
          out_res_d    = (status_q == ptw_pkg::ST_OK) ? res_q : '0;
          out_done_d   = done_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      nf_q        <= NF_W'(1);
      base_q      <= '0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) base_q <= cfg_i.table_base_frame;
      if (dirty_set) dirty_q[slot_q] <= 1'b1;
      if (dirty_clr) dirty_q[new_slot_q] <= 1'b0;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    level_q      <= level_d;
    slot_q       <= slot_d;
    new_slot_q   <= new_slot_d;
    cmd_q        <= cmd_d;
    va_q         <= va_d;
    pa_q         <= pa_d;
    count_q      <= count_d;
    done_q       <= done_d;
    glob_q       <= glob_d;
    status_q     <= status_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
    out_res_q    <= out_res_d;
    out_done_q   <= out_done_d;
  end

  // table store, one access a cycle
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[{slot_q, idx}];
  end

endmodule

// ===== tb/ptw_checker.sv =====
// ptw_checker: watches the configuration, request and response channels of
// the page table walker, models its table store and compares every response.
// Depends on ptw_pkg and ptw_if.
`timescale 1ns / 1ps
module ptw_checker #(
  parameter int unsigned TABLE_PAGES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  ptw_cfg_if   cfg,
  ptw_req_if   req,
  ptw_rsp_if   rsp,
  output int   fail_count,
  output int   pending_count
);
  import ptw_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [VA_W-1:0]  resolved;
    logic [CNT_W-1:0] pages;
  } walk_answer_t;

  localparam int unsigned DEPTH = TABLE_PAGES * 512;

  logic [ENTRY_W-1:0] shadow_store [DEPTH];
  int unsigned        free_slot;
  logic [FRAME_W-1:0] base_frame;
  walk_answer_t       answer_q [$];

  function automatic logic [IDX_W-1:0] va_idx(logic [VA_W-1:0] va, int lvl);
    return va[12 + 9 * (lvl - 1) +: IDX_W];
  endfunction

  // slot an entry points at; 0 when its frame lies outside the store
  function automatic bit entry_to_slot(logic [ENTRY_W-1:0] e, output int unsigned s);
    logic [FRAME_W-1:0] d;
    d = e[51:12] - base_frame;
    s = 0;
    if (d >= TABLE_PAGES) return 1'b0;
    s = d[31:0];
    return 1'b1;
  endfunction

  // follow the entry, allocating a fresh zeroed table when it is empty
  function automatic logic [1:0] walk_or_alloc(int unsigned slot, logic [IDX_W-1:0] idx,
                                               logic [ENTRY_W-1:0] flags,
                                               output int unsigned child);
    int unsigned pos;
    logic [FRAME_W-1:0] fr;
    pos = slot * 512 + idx;
    child = 0;
    if (shadow_store[pos] == '0) begin
      if (free_slot >= TABLE_PAGES) return ST_FULL;
      child = free_slot;
      free_slot++;
      for (int i = 0; i < 512; i++) shadow_store[child * 512 + i] = '0;
      fr = base_frame + child;
      shadow_store[pos] = {12'd0, fr, 12'd0} | flags;
      return ST_OK;
    end
    return entry_to_slot(shadow_store[pos], child) ? ST_OK : ST_OUTSIDE;
  endfunction

  function automatic logic [1:0] map_page(logic [VA_W-1:0] va, logic [PA_W-1:0] pa, bit g);
    logic [ENTRY_W-1:0] dir;
    int unsigned s3, s2, s1;
    logic [1:0] st;
    dir = F_PRESENT | F_WRITE | (g ? '0 : F_USER);
    st = walk_or_alloc(0, va_idx(va, 4), dir | F_ACCESSED, s3);
    if (st != ST_OK) return st;
    st = walk_or_alloc(s3, va_idx(va, 3), dir | F_ACCESSED, s2);
    if (st != ST_OK) return st;
    st = walk_or_alloc(s2, va_idx(va, 2), dir, s1);
    if (st != ST_OK) return st;
    shadow_store[s1 * 512 + va_idx(va, 1)] =
      {12'd0, pa} | F_PRESENT | F_WRITE | (g ? F_GLOBAL : F_USER);
    return ST_OK;
  endfunction

  function automatic walk_answer_t translate(logic [VA_W-1:0] va);
    walk_answer_t a;
    int unsigned s;
    logic [ENTRY_W-1:0] e;
    a = '0;
    s = 0;
    for (int lvl = 4; lvl >= 2; lvl--) begin
      e = shadow_store[s * 512 + va_idx(va, lvl)];
      if (lvl == 2 && e[LARGE_BIT]) begin
        a.resolved = (e & ~LARGE_MASK) | (va & LARGE_MASK);
        return a;
      end
      if (!entry_to_slot(e, s)) begin
        a.status = ST_OUTSIDE;
        return a;
      end
    end
    e = shadow_store[s * 512 + va_idx(va, 1)];
    a.resolved = (e & ~PAGE_MASK) + (va & PAGE_MASK);
    return a;
  endfunction

  function automatic walk_answer_t predict_walk(logic [1:0] cmd, logic [VA_W-1:0] va,
                                               logic [PA_W-1:0] pa, logic [CNT_W-1:0] cnt,
                                               bit g);
    walk_answer_t a;
    logic [VA_W-1:0] off;
    logic [1:0] st;
    a = '0;
    if (cmd == CMD_MAP) begin
      for (int unsigned n = 0; n < cnt; n++) begin
        off = VA_W'(n) << 12;
        st = map_page(va + off, pa + off[PA_W-1:0], g);
        if (st != ST_OK) begin
          a.status = st;
          break;
        end
        a.pages = a.pages + 1'b1;
      end
    end else if (cmd == CMD_RESOLVE) begin
      a = translate(va);
    end else if (cmd == CMD_CLEAR) begin
      for (int i = 256; i < 512; i++) shadow_store[i] = '0;
    end
    return a;
  endfunction

  // beats are sampled at the rising edge, before the block updates them
  always @(posedge clk_i or negedge rst_ni) begin
    walk_answer_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;
      free_slot = 1;
      base_frame = '0;
      answer_q.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) base_frame = cfg.table_base_frame;
      if (req.valid && req.ready)
        answer_q.push_back(predict_walk(req.cmd, req.virtual_address, req.physical_address,
                                        req.page_count, req.global_mapping));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.resolved_address, rsp.pages_mapped};
        if (answer_q.size() == 0) begin
          $display("%0t: response beat with none expected: status %0d addr %h pages %0d",
                   $time, got.status, got.resolved, got.pages);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.resolved !== want.resolved) begin
            $display("%0t: resolved_address exp %h got %h", $time, want.resolved,
                     got.resolved);
            fail_count++;
          end
          if (got.pages !== want.pages) begin
            $display("%0t: pages_mapped exp %0d got %0d", $time, want.pages, got.pages);
            fail_count++;
          end
        end
      end
      pending_count = answer_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: drives requests and table base writes into the page table walker,
// stalls the response side, and reports the verdict from ptw_checker.
// Depends on ptw_pkg, ptw_if, ptw_checker and the walker itself.
`timescale 1ns / 1ps
module tb;
  import ptw_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending_count;
  bit   no_idle;
  logic [VA_W-1:0] mapped_va [$];

  ptw_cfg_if cfg ();
  ptw_req_if req ();
  ptw_rsp_if rsp ();

  four_level_page_table_walker_unit #(.TABLE_PAGES(64)) dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .cfg_i(cfg), .req_i(req), .rsp_o(rsp)
  );

  ptw_checker #(.TABLE_PAGES(64)) u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg(cfg), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("FAIL four_level_page_table_walker_unit");
    $finish;
  end

  // response side: random stall before each beat
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = no_idle ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // indexes drawn from a few hot regions so that tables are shared
  function automatic logic [IDX_W-1:0] hot_idx();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 9'd1;
      default: return 9'd256;
    endcase
  endfunction

  function automatic logic [VA_W-1:0] pick_va(bit spread);
    logic [63:0] r;
    r = rand64();
    if (spread) return r;
    return {r[63:48], hot_idx(), hot_idx(), hot_idx(), r[20:12], r[11:0]};
  endfunction

  // physical base: often a frame inside the store so leaves alias tables
  function automatic logic [PA_W-1:0] pick_pa(logic [FRAME_W-1:0] base);
    logic [63:0] r;
    logic [FRAME_W-1:0] fr;
    r = rand64();
    if ($urandom_range(0, 1)) return r[PA_W-1:0];
    fr = base + FRAME_W'($urandom_range(0, 70));
    return {fr, r[11:0]};
  endfunction

  // one request beat, then the sender's gap
  task automatic send_walk(logic [1:0] cmd, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                           logic [CNT_W-1:0] cnt, bit g);
    int gap;
    req.cmd <= cmd;
    req.virtual_address <= va;
    req.physical_address <= pa;
    req.page_count <= cnt;
    req.global_mapping <= g;
    req.valid <= 1'b1;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (cmd == CMD_MAP && cnt != 0) begin
      mapped_va.push_back(va);
      if (mapped_va.size() > 32) void'(mapped_va.pop_front());
    end
  endtask

  // base register is only moved while the walker is idle
  task automatic write_base(logic [FRAME_W-1:0] fr);
    req.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg.table_base_frame <= fr;
    cfg.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg.ready);
    @(negedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_walk(logic [FRAME_W-1:0] base, bit last);
    logic [1:0] cmd;
    logic [VA_W-1:0] va;
    logic [CNT_W-1:0] cnt;
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) cmd = CMD_MAP;
    else if (k < 96) cmd = CMD_RESOLVE;
    else if (k < 98) cmd = CMD_CLEAR;
    else cmd = 2'd3;
    va = pick_va($urandom_range(0, 99) < (last ? 30 : 2));
    if (cmd == CMD_RESOLVE && mapped_va.size() != 0 && $urandom_range(0, 9) < 6)
      va = mapped_va[$urandom_range(0, mapped_va.size() - 1)]
           + (VA_W'($urandom_range(0, 4)) << 12) + VA_W'($urandom_range(0, 4095));
    k = $urandom_range(0, 99);
    if (k < 80) cnt = CNT_W'($urandom_range(0, 4));
    else if (k < 98) cnt = CNT_W'($urandom_range(5, 40));
    else cnt = CNT_W'($urandom_range(513, 1100));
    send_walk(cmd, va, pick_pa(base), cnt, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [FRAME_W-1:0] bases [8];
    rst_ni = 1'b0;
    no_idle = 1'b0;
    req.valid = 1'b0;
    req.cmd = CMD_MAP;
    req.virtual_address = '0;
    req.physical_address = '0;
    req.page_count = '0;
    req.global_mapping = 1'b0;
    cfg.valid = 1'b0;
    cfg.table_base_frame = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, every command, zero count, unknown command
    send_walk(CMD_MAP, '0, '0, '0, 1'b0);
    send_walk(CMD_MAP, '0, '0, 16'd1, 1'b0);
    send_walk(CMD_RESOLVE, '0, '0, '0, 1'b0);
    send_walk(CMD_MAP, '1, '1, 16'd1, 1'b1);
    send_walk(CMD_RESOLVE, '1, '0, '0, 1'b0);
    send_walk(CMD_MAP, 64'hFFFF_8000_001F_E000, 52'h12345_6789A_BC0, 16'd4, 1'b1);
    send_walk(CMD_RESOLVE, 64'hFFFF_8000_0020_0ABC, '0, '0, 1'b0);
    send_walk(CMD_MAP, 64'h0000_0000_0040_0000, 52'h0000_0000_0508F, 16'd3, 1'b0);
    send_walk(CMD_RESOLVE, 64'h0000_0000_0040_1FFF, '0, '0, 1'b0);
    send_walk(CMD_RESOLVE, 64'h0000_1234_5678_9ABC, '0, '0, 1'b0);
    send_walk(2'd3, '1, '1, '1, 1'b1);
    send_walk(CMD_CLEAR, '0, '0, '0, 1'b0);
    send_walk(CMD_RESOLVE, 64'hFFFF_8000_0020_0ABC, '0, '0, 1'b0);
    send_walk(CMD_RESOLVE, '1, '0, '0, 1'b0);
    send_walk(CMD_MAP, 64'hFFFF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 16'd2, 1'b0);
    send_walk(CMD_RESOLVE, '0, '0, '0, 1'b0);

    // phases under several base frames, extremes included
    bases[0] = '0;
    bases[1] = '1;
    bases[2] = 40'd1;
    bases[3] = FRAME_W'({$urandom, $urandom});
    bases[4] = 40'd2;
    bases[5] = 40'hFF_FFFF_FFF0;
    bases[6] = 40'd3;
    bases[7] = '0;
    for (int p = 0; p < 8; p++) begin
      write_base(bases[p]);
      no_idle = (p % 4 == 2);
      for (int i = 0; i < 250; i++) random_walk(bases[p], p == 7);
    end
    no_idle = 1'b0;
    send_walk(CMD_MAP, pick_va(1'b1), pick_pa(bases[7]), '1, 1'b0);
    send_walk(CMD_RESOLVE, mapped_va[mapped_va.size() - 1], '0, '0, 1'b0);
    req.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS four_level_page_table_walker_unit");
    else
      $display("FAIL four_level_page_table_walker_unit");
    $finish;
  end

endmodule
